### design/mab_pkg.sv
// shared types and codes for the majority-ack reliable broadcast block
// no dependencies; imported by every module of the block

package mab_pkg;

	// request fields of one input item
	typedef struct packed {
		logic        req_type;
		logic [10:0] seq_no;
		logic [4:0]  origin_pid;
		logic [9:0]  msg_index;
		logic [4:0]  from_pid;
	} req_t;

	// fields of one result item
	typedef struct packed {
		logic [1:0] kind;
		logic [9:0] out_index;
		logic [4:0] out_relay;
		logic       last;
	} rsp_t;

	// result kinds
	localparam logic [1:0] KIND_BCAST   = 2'd0;
	localparam logic [1:0] KIND_DELIVER = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// configuration register indexes
	localparam logic CFG_PROC_CNT = 1'b0;
	localparam logic CFG_SELF_ID  = 1'b1;

	// request classes handed from front to back
	typedef enum logic [1:0] {
		OP_LOCAL = 2'd0,
		OP_RECV  = 2'd1,
		OP_ERROR = 2'd2
	} op_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC,
		BK_DELIVER
	} back_state_t;

endpackage

### design/mab_front.sv
// front end: classifies a request and works out its message id
// depends on mab_pkg

module mab_front import mab_pkg::*; #(
	parameter int MAX_MSGS = 1024,
	parameter int NPROC    = 16
) (
	input  req_t                          req,
	input  logic [$clog2(NPROC+1)-1:0]    np,
	output op_t                           op,
	output logic [$clog2(MAX_MSGS)-1:0]   addr,
	output logic [4:0]                    from
);

	localparam int AW = $clog2(MAX_MSGS);
	localparam int EW = $clog2(NPROC+1);
	localparam int SW = EW + 12;

	logic [SW-1:0] prod;
	logic [SW-1:0] sum;
	logic [SW-1:0] lim;
	logic [SW-1:0] diff;
	logic          local_bad;
	logic          recv_bad;

	// local id = np*seq + sender - (np + 1), checked for both ends of the table
	always_comb begin
		prod      = SW'(np) * SW'(req.seq_no);
		sum       = prod + SW'(req.origin_pid);
		lim       = SW'(np) + SW'(1);
		diff      = sum - lim;
		local_bad = (sum < lim) || (32'(diff) >= 32'(MAX_MSGS));
		recv_bad  = 32'(req.msg_index) >= 32'(MAX_MSGS);
	end

	// classification
	always_comb begin
		if (req.req_type) begin
			op   = recv_bad ? OP_ERROR : OP_RECV;
			addr = AW'(req.msg_index);
		end else begin
			op   = local_bad ? OP_ERROR : OP_LOCAL;
			addr = AW'(diff);
		end
		from = req.from_pid;
	end

endmodule

### design/mab_fifo.sv
// small request queue between front and back
// depends on mab_pkg only by convention of the block

module mab_fifo import mab_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### design/mab_back.sv
// back end: clears the message table, then does the read-modify-write per request
// and drives the result register; depends on mab_pkg

module mab_back import mab_pkg::*; #(
	parameter int MAX_MSGS = 1024,
	parameter int NPROC    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(NPROC+1)-1:0]    np,
	input  logic [4:0]                    self_id,
	input  logic                          q_empty,
	input  op_t                           q_op,
	input  logic [$clog2(MAX_MSGS)-1:0]   q_addr,
	input  logic [4:0]                    q_from,
	output logic                          q_pop,
	output logic                          clearing,
	output logic                          rsp_valid,
	output rsp_t                          rsp
);

	localparam int AW = $clog2(MAX_MSGS);
	localparam int EW = $clog2(NPROC+1);
	localparam int MW = NPROC + 2;

	// table: bit NPROC+1 delivered, bit NPROC seen, low bits ack row
	logic [MW-1:0]    mem [MAX_MSGS];
	logic [MW-1:0]    rd_q;

	back_state_t      state_q;
	back_state_t      state_d;
	logic [AW-1:0]    clr_q;
	op_t              op_q;
	logic [AW-1:0]    addr_q;
	logic [4:0]       from_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [MW-1:0]    mem_wdata;
	logic             mem_re;
	logic             take;
	logic             emit;
	rsp_t             emit_rsp;

	logic             self_ok;
	logic             from_ok;
	logic [NPROC-1:0] self_bit;
	logic [NPROC-1:0] from_bit;
	logic [NPROC-1:0] np_mask;
	logic [NPROC-1:0] row_local;
	logic [NPROC-1:0] row_recv;
	logic [NPROC-1:0] row_cnt;
	logic [EW-1:0]    cnt;
	logic             was_seen;
	logic             was_deliv;
	logic             rebcast;
	logic             dlv;
	logic [9:0]       idx_out;

	assign clearing  = (state_q == BK_CLEAR);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign idx_out   = 10'(addr_q);

	// ack bits and majority test for the entry under work
	always_comb begin
		self_ok   = (self_id != 5'd0) && ({3'b0, self_id} <= 8'(np));
		from_ok   = (from_q != 5'd0) && ({3'b0, from_q} <= 8'(np));
		self_bit  = self_ok ? (NPROC'(1) << (self_id - 5'd1)) : '0;
		from_bit  = from_ok ? (NPROC'(1) << (from_q - 5'd1)) : '0;
		for (int i = 0; i < NPROC; i++) begin
			np_mask[i] = (32'(i) < 32'(np));
		end
		was_seen  = rd_q[NPROC];
		was_deliv = rd_q[NPROC+1];
		rebcast   = !was_seen;
		row_local = rd_q[NPROC-1:0] | self_bit;
		row_recv  = rd_q[NPROC-1:0] | from_bit | (rebcast ? self_bit : '0);
		row_cnt   = row_recv & np_mask;
		cnt       = '0;
		for (int i = 0; i < NPROC; i++) begin
			cnt = cnt + EW'(row_cnt[i]);
		end
		dlv       = (cnt > (np >> 1)) && !was_deliv;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_q == AW'(MAX_MSGS-1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (!q_empty && (q_op != OP_ERROR)) state_d = BK_EXEC;
			end
			BK_EXEC: begin
				if ((op_q == OP_RECV) && rebcast && dlv) state_d = BK_DELIVER;
				else state_d = BK_IDLE;
			end
			BK_DELIVER: begin
				state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs, memory controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		q_pop     = 1'b0;
		take      = 1'b0;
		emit      = 1'b0;
		emit_rsp  = '{kind: KIND_BCAST, out_index: idx_out, out_relay: self_id, last: 1'b1};
		unique case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_op == OP_ERROR) begin
						emit     = 1'b1;
						emit_rsp = '{kind: KIND_ERROR, out_index: 10'd0, out_relay: 5'd0,
							last: 1'b1};
					end else begin
						mem_re = 1'b1;
						take   = 1'b1;
					end
				end
			end
			BK_EXEC: begin
				mem_we = 1'b1;
				if (op_q == OP_LOCAL) begin
					mem_wdata = {was_deliv, 1'b1, row_local};
					emit      = 1'b1;
				end else begin
					mem_wdata = {was_deliv | dlv, 1'b1, row_recv};
					if (rebcast) begin
						emit     = 1'b1;
						emit_rsp = '{kind: KIND_BCAST, out_index: idx_out, out_relay: self_id,
							last: !dlv};
					end else if (dlv) begin
						emit     = 1'b1;
						emit_rsp = '{kind: KIND_DELIVER, out_index: idx_out, out_relay: 5'd0,
							last: 1'b1};
					end
				end
			end
			BK_DELIVER: begin
				emit     = 1'b1;
				emit_rsp = '{kind: KIND_DELIVER, out_index: idx_out, out_relay: 5'd0,
					last: 1'b1};
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= emit;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// request latch and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= q_op;
			addr_q <= q_addr;
			from_q <= q_from;
		end
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

	// message table, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[q_addr];
		end
	end

endmodule

### design/majority_ack_reliable_broadcast.sv
// top level of the majority-ack reliable broadcast block
// depends on mab_pkg, mab_front, mab_fifo, mab_back
//
//  channel  | handshake          | payload             | direction
//  ---------+--------------------+---------------------+----------
//  request  | start / busy       | req   (req_t)       | in
//  result   | rsp_valid strobe   | rsp   (rsp_t)       | out
//  config   | cfg_we             | cfg_index/cfg_wdata | in
//
// after reset the message table is cleared entry by entry with busy high.
// a request is taken when start is high and busy low; busy also rises while
// the two-entry request queue is full. the back end reads the table entry of a
// request when it leaves the queue, then writes the update and registers the
// result; a rebroadcast followed by a deliver adds a deliver step, and an error
// result is registered straight from the queue with no table access. results
// come as strobes, at most one per cycle, and cannot be held off.

module majority_ack_reliable_broadcast import mab_pkg::*; #(
	parameter int MAX_MSGS = 1024,
	parameter int NPROC    = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       rsp_valid,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [4:0] cfg_wdata
);

	localparam int AW = $clog2(MAX_MSGS);
	localparam int EW = $clog2(NPROC+1);
	localparam int QW = 2 + AW + 5;

	logic [4:0]    proc_cnt_q;
	logic [4:0]    self_id_q;
	logic [EW-1:0] np;

	op_t           f_op;
	logic [AW-1:0] f_addr;
	logic [4:0]    f_from;
	logic          q_push;
	logic          q_pop;
	logic [QW-1:0] q_rdata;
	logic          q_empty;
	logic          q_full;
	logic          clearing;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_cnt_q <= 5'd1;
			self_id_q  <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROC_CNT: proc_cnt_q <= cfg_wdata;
				CFG_SELF_ID:  self_id_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective process count, clamped to 1..NPROC
	always_comb begin
		priority if (proc_cnt_q == 5'd0) begin
			np = EW'(1);
		end else if (32'(proc_cnt_q) > 32'(NPROC)) begin
			np = EW'(NPROC);
		end else begin
			np = EW'(proc_cnt_q);
		end
	end

	assign busy   = clearing || q_full;
	assign q_push = start && !busy;

	mab_front #(
		.MAX_MSGS(MAX_MSGS),
		.NPROC   (NPROC)
	) u_front (
		.req (req),
		.np  (np),
		.op  (f_op),
		.addr(f_addr),
		.from(f_from)
	);

	mab_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({f_op, f_addr, f_from}),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty),
		.full  (q_full)
	);

	mab_back #(
		.MAX_MSGS(MAX_MSGS),
		.NPROC   (NPROC)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.np       (np),
		.self_id  (self_id_q),
		.q_empty  (q_empty),
		.q_op     (op_t'(q_rdata[QW-1 -: 2])),
		.q_addr   (q_rdata[AW+4:5]),
		.q_from   (q_rdata[4:0]),
		.q_pop    (q_pop),
		.clearing (clearing),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

### dv/mab_checker.sv
`timescale 1ns / 100ps
// watches the request, result and config channels of the broadcast block
// keeps its own copy of the message table and compares every result in order
// depends on mab_pkg

module mab_checker import mab_pkg::*; #(
	parameter int MAX_MSGS = 1024,
	parameter int NPROC    = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  req_t       req,
	input  logic       rsp_valid,
	input  rsp_t       rsp,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [4:0] cfg_wdata,
	output int         mismatches,
	output int         results_owed,
	output int         requests_taken,
	output int         results_seen,
	output int         delivers_seen,
	output int         errors_seen
);

	// shadow of the message table: bit 0 seen, bit 1 delivered
	logic [1:0]       msg_flags [MAX_MSGS];
	logic [NPROC-1:0] ack_bits  [MAX_MSGS];
	logic [4:0]       proc_cnt;
	logic [4:0]       self_id;

	// results still owed by the block, oldest first
	rsp_t owed_rsp [$];

	int errs;
	int n_req;
	int n_rsp;
	int n_deliv;
	int n_err;

	assign mismatches     = errs;
	assign requests_taken = n_req;
	assign results_seen   = n_rsp;
	assign delivers_seen  = n_deliv;
	assign errors_seen    = n_err;

	function automatic int active_procs();
		if (proc_cnt == 0)
			return 1;
		if (proc_cnt > NPROC)
			return NPROC;
		return proc_cnt;
	endfunction

	task automatic mark_ack(input int id, input int pid, input int np);
		if (pid >= 1 && pid <= np)
			ack_bits[id][pid-1] = 1'b1;
	endtask

	task automatic owe(input logic [1:0] kind, input int idx, input logic [4:0] relay,
			input logic last);
		rsp_t e;
		e.kind      = kind;
		e.out_index = idx[9:0];
		e.out_relay = relay;
		e.last      = last;
		owed_rsp.push_back(e);
	endtask

	// update the shadow table for one request and queue what it must produce
	task automatic apply_request(input req_t r);
		int np;
		int id;
		logic [NPROC-1:0] mask;
		logic rebcast;
		logic deliver;
		np = active_procs();
		mask = (np >= NPROC) ? '1 : NPROC'((1 << np) - 1);
		if (r.req_type == 1'b0) begin
			id = np * (int'(r.seq_no) - 1) + int'(r.origin_pid) - 1;
			if (id < 0 || id >= MAX_MSGS) begin
				owe(KIND_ERROR, 0, 5'd0, 1'b1);
			end else begin
				msg_flags[id][0] = 1'b1;
				mark_ack(id, self_id, np);
				owe(KIND_BCAST, id, self_id, 1'b1);
			end
		end else begin
			id = int'(r.msg_index);
			if (id >= MAX_MSGS) begin
				owe(KIND_ERROR, 0, 5'd0, 1'b1);
			end else begin
				mark_ack(id, r.from_pid, np);
				rebcast = !msg_flags[id][0];
				if (rebcast) begin
					msg_flags[id][0] = 1'b1;
					mark_ack(id, self_id, np);
				end
				deliver = ($countones(ack_bits[id] & mask) > np / 2) && !msg_flags[id][1];
				if (deliver)
					msg_flags[id][1] = 1'b1;
				if (rebcast)
					owe(KIND_BCAST, id, self_id, !deliver);
				if (deliver)
					owe(KIND_DELIVER, id, 5'd0, 1'b1);
			end
		end
	endtask

	task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < MAX_MSGS; i++) begin
				msg_flags[i] = '0;
				ack_bits[i]  = '0;
			end
			proc_cnt = 5'd1;
			self_id  = 5'd1;
			owed_rsp.delete();
			errs    = 0;
			n_req   = 0;
			n_rsp   = 0;
			n_deliv = 0;
			n_err   = 0;
			results_owed <= 0;
		end else begin
			// compare the result of this cycle with the oldest one owed
			if (rsp_valid) begin
				n_rsp++;
				if (rsp.kind == KIND_DELIVER)
					n_deliv++;
				if (rsp.kind == KIND_ERROR)
					n_err++;
				if (owed_rsp.size() == 0) begin
					$display("%0t: unexpected result kind=%0d index=%0d relay=%0d last=%0d",
						$time, rsp.kind, rsp.out_index, rsp.out_relay, rsp.last);
					errs++;
				end else begin
					e = owed_rsp.pop_front();
					cmp_field("kind", e.kind, rsp.kind);
					cmp_field("out_index", e.out_index, rsp.out_index);
					cmp_field("out_relay", e.out_relay, rsp.out_relay);
					cmp_field("last", e.last, rsp.last);
				end
			end
			// accepted request
			if (start && !busy) begin
				n_req++;
				apply_request(req);
			end
			// register writes
			if (cfg_we) begin
				if (cfg_index == CFG_PROC_CNT)
					proc_cnt = cfg_wdata;
				else
					self_id = cfg_wdata;
			end
			results_owed <= owed_rsp.size();
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// top of the broadcast block testbench: clock, reset, requests and config writes
// depends on mab_pkg, majority_ack_reliable_broadcast and mab_checker

module tb_top import mab_pkg::*; ();

	localparam int MAX_MSGS       = 1024;
	localparam int NPROC          = 16;
	localparam int N_PHASES       = 10;
	localparam int RAND_PER_PHASE = 128;
	localparam int SETTLE_CYCLES  = 24;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	req_t       req       = '0;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = CFG_PROC_CNT;
	logic [4:0] cfg_wdata = '0;
	logic       busy;
	logic       rsp_valid;
	rsp_t       rsp;

	int mismatches;
	int results_owed;
	int requests_taken;
	int results_seen;
	int delivers_seen;
	int errors_seen;

	// current setting and the message group being built
	int cur_np;
	int grp_left;
	int grp_id;
	int n_settings;

	always #6 clk = ~clk;

	majority_ack_reliable_broadcast #(
		.MAX_MSGS(MAX_MSGS),
		.NPROC   (NPROC)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	mab_checker #(
		.MAX_MSGS(MAX_MSGS),
		.NPROC   (NPROC)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp           (rsp),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.results_owed  (results_owed),
		.requests_taken(requests_taken),
		.results_seen  (results_seen),
		.delivers_seen (delivers_seen),
		.errors_seen   (errors_seen)
	);

	function automatic int eff_np();
		if (cur_np == 0)
			return 1;
		if (cur_np > NPROC)
			return NPROC;
		return cur_np;
	endfunction

	// local broadcast request, unused fields random
	function automatic req_t mk_local(input logic [10:0] seq, input logic [4:0] snd);
		req_t r;
		r = req_t'($urandom);
		r.req_type   = 1'b0;
		r.seq_no     = seq;
		r.origin_pid = snd;
		return r;
	endfunction

	// received copy, unused fields random
	function automatic req_t mk_recv(input logic [9:0] idx, input logic [4:0] from);
		req_t r;
		r = req_t'($urandom);
		r.req_type  = 1'b1;
		r.msg_index = idx;
		r.from_pid  = from;
		return r;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// hold the request until it is taken, then idle for gap cycles
	task automatic send(input req_t r, input int gap);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending, wait until every owed result is back and the block is quiet
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [4:0] np, input logic [4:0] sid);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PROC_CNT;
		cfg_wdata <= np;
		@(posedge clk);
		cfg_index <= CFG_SELF_ID;
		cfg_wdata <= sid;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_np = np;
		n_settings++;
	endtask

	// groups of copies of one message, with a share of raw noise
	task automatic pick_item(output req_t r);
		int np;
		int from;
		np = eff_np();
		if ($urandom_range(0, 99) < 25) begin
			r = req_t'($urandom);
		end else if (grp_left == 0) begin
			grp_id   = $urandom_range(0, MAX_MSGS - 1);
			grp_left = $urandom_range(1, np + 3);
			if ($urandom_range(0, 1))
				r = mk_local(11'(grp_id / np + 1), 5'(grp_id % np + 1));
			else
				r = mk_recv(10'(grp_id), 5'($urandom_range(1, np)));
		end else begin
			grp_left--;
			if ($urandom_range(0, 9) == 0)
				from = $urandom_range(0, 31);
			else
				from = $urandom_range(1, np);
			r = mk_recv(10'(grp_id), 5'(from));
		end
	endtask

	// edge cases with one process: bad ids, table end, deliver paths
	task automatic directed_one_proc();
		send(mk_local(11'd1, 5'd1), pick_gap());
		send(mk_local(11'd0, 5'd1), pick_gap());
		send(mk_local(11'd1, 5'd0), pick_gap());
		send(mk_local(11'd2047, 5'd31), pick_gap());
		send(mk_local(11'd1024, 5'd1), pick_gap());
		send(mk_local(11'd1025, 5'd1), pick_gap());
		send(mk_recv(10'd1023, 5'd1), pick_gap());
		send(mk_recv(10'd5, 5'd0), pick_gap());
		send(mk_recv(10'd5, 5'd16), pick_gap());
		send(mk_local(11'd1, 5'd1), pick_gap());
		send(mk_recv(10'd0, 5'd31), pick_gap());
		send(mk_recv(10'd0, 5'd1), pick_gap());
		send(mk_recv(10'd1023, 5'd16), pick_gap());
	endtask

	// full process count: table end and a majority built up copy by copy
	task automatic directed_full();
		send(mk_local(11'd64, 5'd16), pick_gap());
		send(mk_local(11'd65, 5'd1), pick_gap());
		send(mk_local(11'd1, 5'd16), pick_gap());
		for (int p = 1; p <= 9; p++)
			send(mk_recv(10'd900, 5'(p)), pick_gap());
	endtask

	initial begin
		req_t r;
		logic calm;
		logic [4:0] np;
		logic [4:0] sid;
		grp_left   = 0;
		grp_id     = 0;
		cur_np     = 1;
		n_settings = 0;
		calm       = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// table clear pass after reset
		@(posedge clk);
		while (busy)
			@(posedge clk);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin np = 5'd1;  sid = 5'd1;  end
				1: begin np = 5'd16; sid = 5'd16; end
				2: begin np = 5'd5;  sid = 5'd3;  end
				3: begin np = 5'd0;  sid = 5'd1;  end
				4: begin np = 5'd31; sid = 5'd7;  end
				5: begin np = 5'd4;  sid = 5'd0;  end
				6: begin np = 5'd8;  sid = 5'd12; end
				7: begin np = 5'd2;  sid = 5'd2;  end
				8: begin np = 5'd3;  sid = 5'd1;  end
				default: begin np = 5'd16; sid = 5'd1; end
			endcase
			write_cfg(np, sid);
			grp_left = 0;
			if (ph == 0)
				directed_one_proc();
			if (ph == 1)
				directed_full();
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (i % 32 == 0)
					calm = ($urandom_range(0, 3) == 0);
				pick_item(r);
				send(r, calm ? 0 : pick_gap());
				// occasional pause until every result is back
				if ($urandom_range(0, 99) == 0)
					drain();
			end
			drain();
		end

		$display("covered %0d requests over %0d register settings", requests_taken, n_settings);
		$display("checked %0d results, %0d delivers and %0d errors among them",
			results_seen, delivers_seen, errors_seen);
		if (mismatches == 0 && results_owed == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
design/mab_pkg.sv
design/mab_front.sv
design/mab_fifo.sv
design/mab_back.sv
design/majority_ack_reliable_broadcast.sv
dv/mab_checker.sv
dv/tb_top.sv
